### rtl/hss_pkg.sv
// Shared types and constants for the heat stencil sweep block.
`default_nettype none

package hss_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int RATIO_W     = 16;
	localparam int RATIO_FRAC  = 16;
	localparam int LAP_W       = SAMPLE_W + 2;
	localparam int PROD_W      = LAP_W + RATIO_W + 1;
	localparam int SHIFT_W     = PROD_W - RATIO_FRAC;
	localparam int SUM_W       = SHIFT_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(32768);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ONE,
		PH_WINDOW
	} phase_t;

	typedef struct packed {
		logic    do_stencil;
		logic    do_boundary;
		logic    last;
		sample_t left;
		sample_t centre;
		sample_t right;
		sample_t bval;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/hss_front.sv
// Front end: tracks the sweep position and turns input beats into stencil commands.
`default_nettype none

module hss_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            queue_full,
	input  wire hss_pkg::sample_t sample,
	input  wire logic            is_first,
	input  wire logic            is_last,
	input  wire hss_pkg::sample_t boundary_value,
	output logic                 push,
	output hss_pkg::cmd_t        cmd
);
	import hss_pkg::*;

	phase_t  phase_q, phase_next;
	sample_t left_q, centre_q;
	logic    accept;

	assign accept = in_valid && !queue_full;

	always_comb begin
		phase_next = phase_q;
		if (is_first) begin
			phase_next = is_last ? PH_IDLE : PH_ONE;
		end else begin
			case (phase_q)
				PH_ONE:    phase_next = is_last ? PH_IDLE : PH_WINDOW;
				PH_WINDOW: phase_next = is_last ? PH_IDLE : PH_WINDOW;
				default:   phase_next = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.do_stencil  = 1'b0;
		cmd.do_boundary = 1'b0;
		cmd.last        = is_last;
		cmd.left        = left_q;
		cmd.centre      = centre_q;
		cmd.right       = sample;
		cmd.bval        = boundary_value;
		if (is_first) begin
			cmd.do_boundary = 1'b1;
		end else begin
			case (phase_q)
				PH_ONE: begin
					cmd.do_boundary = is_last;
				end
				PH_WINDOW: begin
					cmd.do_stencil  = 1'b1;
					cmd.do_boundary = is_last;
				end
				default: begin
					cmd.do_boundary = 1'b0;
				end
			endcase
		end
		push = accept && (cmd.do_stencil || cmd.do_boundary);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			left_q   <= '0;
			centre_q <= '0;
		end else if (accept) begin
			phase_q <= phase_next;
			if (is_first) begin
				left_q   <= '0;
				centre_q <= sample;
			end else if (phase_q inside {PH_ONE, PH_WINDOW}) begin
				left_q   <= centre_q;
				centre_q <= sample;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/hss_queue.sv
// Short command queue between the front end and the arithmetic back end.
`default_nettype none

module hss_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire hss_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output hss_pkg::cmd_t      head_cmd,
	output logic               full,
	output logic               empty
);
	import hss_pkg::*;

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full     = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue read while empty");

endmodule

`default_nettype wire

### rtl/hss_back.sv
// Back end: stencil arithmetic pipeline, rounding, saturation and the output register.
`default_nettype none

module hss_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_data,
	input  wire hss_pkg::cmd_t      head_cmd,
	input  wire logic               queue_empty,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output hss_pkg::sample_t        new_sample,
	output logic                    end_of_sweep
);
	import hss_pkg::*;

	logic [RATIO_W-1:0] ratio_q;

	logic                     valid_s1, valid_s2, valid_s3;
	cmd_t                     cmd_s1;
	logic signed [LAP_W-1:0]  lap_s2;
	logic signed [PROD_W-1:0] prod_s3;
	sample_t                  centre_s2, centre_s3, bval_s2, bval_s3;
	logic                     stencil_s2, stencil_s3, boundary_s2, boundary_s3;
	logic                     last_s2, last_s3;

	logic                     first_done_q;
	logic                     out_valid_q, end_q;
	sample_t                  new_sample_q;

	logic signed [LAP_W-1:0]  lap;
	logic signed [PROD_W-1:0] rounded;
	logic signed [SHIFT_W-1:0] shifted;
	logic signed [SUM_W-1:0]  sum;
	sample_t                  sat;
	logic                     both, emit_stencil, out_free, emit, s3_done, adv;

	assign lap = LAP_W'(cmd_s1.left) - (LAP_W'(cmd_s1.centre) <<< 1) + LAP_W'(cmd_s1.right);

	// Round half up: add half an LSB, then the part-select floors the shift.
	assign rounded = prod_s3 + (PROD_W'(1) <<< (RATIO_FRAC - 1));
	assign shifted = $signed(rounded[PROD_W-1:RATIO_FRAC]);
	assign sum     = SUM_W'(centre_s3) + SUM_W'(shifted);

	always_comb begin
		if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1) begin
			sat = sum[SAMPLE_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// An interior point followed by the last boundary takes two output beats.
	assign both         = stencil_s3 && boundary_s3;
	assign emit_stencil = stencil_s3 && !first_done_q;
	assign out_free     = !out_valid_q || !out_stall;
	assign emit         = valid_s3 && out_free;
	assign s3_done      = emit && !(both && !first_done_q);
	assign adv          = !valid_s3 || s3_done;
	assign pop          = adv && !queue_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q      <= RATIO_RESET;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			first_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				ratio_q <= cfg_data;
			end
			if (adv) begin
				valid_s1 <= pop;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
			if (emit) begin
				first_done_q <= both && !first_done_q;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1      <= head_cmd;
			lap_s2      <= lap;
			centre_s2   <= cmd_s1.centre;
			bval_s2     <= cmd_s1.bval;
			stencil_s2  <= cmd_s1.do_stencil;
			boundary_s2 <= cmd_s1.do_boundary;
			last_s2     <= cmd_s1.last;
			prod_s3     <= lap_s2 * $signed({1'b0, ratio_q});
			centre_s3   <= centre_s2;
			bval_s3     <= bval_s2;
			stencil_s3  <= stencil_s2;
			boundary_s3 <= boundary_s2;
			last_s3     <= last_s2;
		end
		if (emit) begin
			new_sample_q <= emit_stencil ? sat : bval_s3;
			end_q        <= emit_stencil ? 1'b0 : last_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign new_sample   = new_sample_q;
	assign end_of_sweep = end_q;

	a_split_only_when_both: assert property (@(posedge clk) disable iff (!arst_n)
		first_done_q |-> valid_s3 && stencil_s3 && boundary_s3)
		else $error("second beat pending on a command with one result");

	a_cmd_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> stencil_s3 || boundary_s3)
		else $error("command without any result reached the last stage");

endmodule

`default_nettype wire

### rtl/heat_stencil_sweep_top.sv
// Top level of the heat stencil sweep block: one explicit 1D heat-equation time step.
//
// Input channel: in_valid / in_stall with sample, is_first, is_last and boundary_value;
// a beat is taken at a clock edge with in_valid high and in_stall low. Samples arrive in
// grid order; is_first opens a sweep and is_last closes it.
// Output channel: out_valid / out_stall with new_sample and end_of_sweep, in grid order.
// The first point yields its boundary value at once; each interior point is emitted when
// its right neighbour arrives; the last point yields the pending interior point and then
// its boundary value. Beats outside a sweep are dropped.
// Configuration: cfg_we writes cfg_data into the diffusion ratio (Q0.16); the user must
// write it only while idle, as the block itself does not enforce this.
// Throughput: one beat per cycle while in_stall is low; a last point after an interior
// window holds the final stage until it has produced both of its output beats.
// in_stall rises when the four-entry command queue is full; an output stall freezes the
// arithmetic pipeline, and the queue then fills before the input side is held.
// Reset empties the queue and pipeline, awaits a first point and sets the ratio to 0.5.
`default_nettype none

module heat_stencil_sweep_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire hss_pkg::sample_t sample,
	input  wire logic             is_first,
	input  wire logic             is_last,
	input  wire hss_pkg::sample_t boundary_value,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output hss_pkg::sample_t      new_sample,
	output logic                  end_of_sweep
);
	import hss_pkg::*;

	cmd_t push_cmd, head_cmd;
	logic push, pop, full, empty;

	assign in_stall = full;

	hss_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.queue_full     (full),
		.sample         (sample),
		.is_first       (is_first),
		.is_last        (is_last),
		.boundary_value (boundary_value),
		.push           (push),
		.cmd            (push_cmd)
	);

	hss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (full),
		.empty    (empty)
	);

	hss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.head_cmd     (head_cmd),
		.queue_empty  (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.new_sample   (new_sample),
		.end_of_sweep (end_of_sweep)
	);

endmodule

`default_nettype wire
